FILE: rtl/frame_presentation_tracker_defines.svh
// Assertion macros shared by the frame presentation tracker RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef FRAME_PRESENTATION_TRACKER_DEFINES_SVH
`define FRAME_PRESENTATION_TRACKER_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define FPT_ASSERT_IMP(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// Check that a condition implies another in the next cycle
`define FPT_ASSERT_NXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

FILE: rtl/fpt_pkg.sv
// Shared constants and types for the frame presentation tracker.
// Depends on nothing; imported by fpt_ifs, fpt_div and the tracker RTL.
`timescale 1ns / 1ps

package fpt_pkg;

  localparam int MAX_PENDING = 16;
  localparam int SLOT_W      = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
  localparam int CNT_W       = $clog2(MAX_PENDING + 1);
  localparam int PEND_OUT_W  = 5;
  localparam int CFG_IDX_W   = 8;
  localparam int DIV_STEPS   = 64;
  localparam int DIV_CNT_W   = 6;

  localparam logic [31:0] NS_PER_SEC = 32'd1000000000;

  // Opcodes
  localparam logic [2:0] OP_REQUEST   = 3'd0;
  localparam logic [2:0] OP_PRESENTED = 3'd1;
  localparam logic [2:0] OP_DISCARDED = 3'd2;
  localparam logic [2:0] OP_OTHER     = 3'd3;
  localparam logic [2:0] OP_PREDICT   = 3'd4;

  // Result status codes
  localparam logic [2:0] STAT_STORED    = 3'd0;
  localparam logic [2:0] STAT_PRESENTED = 3'd1;
  localparam logic [2:0] STAT_DISCARDED = 3'd2;
  localparam logic [2:0] STAT_IGNORED   = 3'd3;
  localparam logic [2:0] STAT_NO_MATCH  = 3'd4;
  localparam logic [2:0] STAT_REJECTED  = 3'd5;
  localparam logic [2:0] STAT_PREDICTED = 3'd6;
  localparam logic [2:0] STAT_NO_PRED   = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOUND = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POID  = 8'd1;

  typedef struct packed {
    logic [31:0] fb_id;
    logic [63:0] cmt_seq;
    logic [63:0] commit_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [2:0]            status;
    logic [31:0]           fb_id;
    logic [63:0]           pres_time;
    logic [63:0]           sequence_res;
    logic [31:0]           refresh_per;
    logic [31:0]           flags;
    logic [63:0]           done_cmt_seq;
    logic [63:0]           latency;
    logic [63:0]           jitter;
    logic [63:0]           next_vsync_ns;
    logic [PEND_OUT_W-1:0] pend_cnt;
  } res_t;

endpackage

FILE: rtl/fpt_ifs.sv
// Valid/ready channel interfaces of the frame presentation tracker.
// Depends on fpt_pkg for the configuration index width.
`timescale 1ns / 1ps

interface fpt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] target_id;
  logic [31:0] surf_id;
  logic [63:0] cmt_seq;
  logic [63:0] time_ns;
  logic [63:0] sec;
  logic [29:0] nsec;
  logic [31:0] refresh_in;
  logic [63:0] seq_in;
  logic [31:0] flags_in;

  modport source (output valid, opcode, target_id, surf_id, cmt_seq, time_ns, sec,
                  nsec, refresh_in, seq_in, flags_in, input ready);
  modport sink (input valid, opcode, target_id, surf_id, cmt_seq, time_ns, sec,
                nsec, refresh_in, seq_in, flags_in, output ready);
endinterface

interface fpt_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [31:0]        fb_id;
  logic [63:0]        pres_time;
  logic [63:0]        sequence_res;
  logic [31:0]        refresh_per;
  logic [31:0]        flags;
  logic [63:0]        done_cmt_seq;
  logic [63:0]        latency;
  logic signed [63:0] jitter;
  logic [63:0]        next_vsync_ns;
  logic [4:0]         pend_cnt;

  modport source (output valid, status, fb_id, pres_time, sequence_res,
                  refresh_per, flags, done_cmt_seq, latency, jitter,
                  next_vsync_ns, pend_cnt, input ready);
  modport sink (input valid, status, fb_id, pres_time, sequence_res,
                refresh_per, flags, done_cmt_seq, latency, jitter,
                next_vsync_ns, pend_cnt, output ready);
endinterface

interface fpt_cfg_if import fpt_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/fpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module fpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_r <= mem[raddr_i];
  end

  assign rdata_o = rdata_r;

endmodule

FILE: rtl/fpt_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Depends on fpt_pkg for the step count.
`timescale 1ns / 1ps

module fpt_div import fpt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [63:0]          quo_r, quo_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [31:0]          dsr_r, dsr_nxt;
  logic [32:0]          trial;
  logic [32:0]          diff;
  logic                 ge;

  // Shift one dividend bit into the remainder and try a subtract
  always_comb begin
    trial    = {rem_r, quo_r[63]};
    diff     = trial - {1'b0, dsr_r};
    ge       = (trial >= {1'b0, dsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend_i;
      rem_nxt  = '0;
      dsr_nxt  = divisor_i;
    end else if (busy_r) begin
      quo_nxt = {quo_r[62:0], ge};
      rem_nxt = ge ? diff[31:0] : trial[31:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Advance the datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done_o     = done_r;
  assign quotient_o = quo_r;

endmodule

FILE: rtl/frame_presentation_tracker.sv
// Frame presentation tracker: one request in, one result out. Pending requests live
// in a 16-entry slot RAM with one valid flop per slot; the valid flops are cleared at
// reset, so no clearing pass is needed. The block takes one request at a time. A
// stored request passes the put state on its way to emit; when the table is full,
// slot 0 is first evicted by a read/write sweep through the RAM. A presented or
// discarded event scans the RAM with a read and a check per slot; a presented event
// then does the presentation time math on the shared 32x32 multiplier. A predict runs
// the 64-step serial divider and then the multiplier, or skips the divider when the
// current time is before the last presentation. Rejected, ignored and no-prediction
// results go straight to the emit step. A result waits in the output register while
// the next request is taken. Depends on fpt_pkg, fpt_ifs, fpt_ram, fpt_div.
`timescale 1ns / 1ps
`include "frame_presentation_tracker_defines.svh"

module frame_presentation_tracker import fpt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  fpt_cfg_if.sink    cfg_ch,
  fpt_in_if.sink     in_ch,
  fpt_out_if.source  out_ch
);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_SH_RD  = 12'b0000_0000_0010,
    ST_SH_WR  = 12'b0000_0000_0100,
    ST_PUT    = 12'b0000_0000_1000,
    ST_SC_RD  = 12'b0000_0001_0000,
    ST_SC_CHK = 12'b0000_0010_0000,
    ST_DIV    = 12'b0000_0100_0000,
    ST_MUL_LO = 12'b0000_1000_0000,
    ST_MUL_HI = 12'b0001_0000_0000,
    ST_SUM    = 12'b0010_0000_0000,
    ST_CALC   = 12'b0100_0000_0000,
    ST_EMIT   = 12'b1000_0000_0000
  } state_t;

  // Control state
  state_t                 state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [MAX_PENDING-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]       pend_r, pend_nxt;
  logic                   bound_r, bound_nxt;
  logic [31:0]            poid_r, poid_nxt;
  logic [63:0]            last_time_r, last_time_nxt;
  logic [31:0]            last_ref_r, last_ref_nxt;

  // Request payload and working registers
  logic [2:0]        op_r, op_nxt;
  logic [31:0]       oid_r, oid_nxt;
  logic [63:0]       cseq_r, cseq_nxt;
  logic [63:0]       time_r, time_nxt;
  logic [63:0]       sec_r, sec_nxt;
  logic [29:0]       nsec_r, nsec_nxt;
  logic [31:0]       refr_in_r, refr_in_nxt;
  logic [63:0]       seq_in_r, seq_in_nxt;
  logic [31:0]       flags_in_r, flags_in_nxt;
  logic [SLOT_W-1:0] k_r, k_nxt;
  logic [SLOT_W-1:0] put_idx_r, put_idx_nxt;
  logic              full_r, full_nxt;
  entry_t            ent_r, ent_nxt;
  logic [63:0]       mul_a_r, mul_a_nxt;
  logic [63:0]       prod_r, prod_nxt;
  logic [63:0]       lo_r, lo_nxt;
  logic [63:0]       acc_r, acc_nxt;
  res_t              res_r, res_nxt;
  res_t              out_r, out_nxt;

  // RAM and divider hookup
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  entry_t            ram_rdata;
  logic              div_start;
  logic              div_done;
  logic [63:0]       div_quo;

  logic [SLOT_W-1:0] free_idx;
  logic [31:0]       mul_b;
  logic [63:0]       addend;
  logic [63:0]       sum64;

  fpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PENDING)
  ) u_slots (
    .clk     (clk),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fpt_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (in_ch.time_ns - last_time_r),
    .divisor_i  (last_ref_r),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Find the first free slot; the last slot when the table is full
  always_comb begin
    free_idx = SLOT_W'(MAX_PENDING - 1);
    for (int i = MAX_PENDING - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  // Select multiplier and adder operands by operation
  assign mul_b  = (op_r == OP_PREDICT) ? last_ref_r : NS_PER_SEC;
  assign addend = (op_r == OP_PREDICT) ? last_time_r : {34'd0, nsec_r};
  assign sum64  = lo_r + {prod_r[31:0], 32'd0} + addend;

  // Main sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    valid_nxt     = valid_r;
    pend_nxt      = pend_r;
    bound_nxt     = bound_r;
    poid_nxt      = poid_r;
    last_time_nxt = last_time_r;
    last_ref_nxt  = last_ref_r;
    op_nxt        = op_r;
    oid_nxt       = oid_r;
    cseq_nxt      = cseq_r;
    time_nxt      = time_r;
    sec_nxt       = sec_r;
    nsec_nxt      = nsec_r;
    refr_in_nxt   = refr_in_r;
    seq_in_nxt    = seq_in_r;
    flags_in_nxt  = flags_in_r;
    k_nxt         = k_r;
    put_idx_nxt   = put_idx_r;
    full_nxt      = full_r;
    ent_nxt       = ent_r;
    mul_a_nxt     = mul_a_r;
    prod_nxt      = prod_r;
    lo_nxt        = lo_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = k_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = k_r;
    div_start     = 1'b0;

    // Take configuration writes
    if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_BOUND) begin
        bound_nxt = cfg_ch.data[0];
      end else if (cfg_ch.index == REG_POID) begin
        poid_nxt = cfg_ch.data;
      end
    end

    // Drop the result once the sink takes it
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt       = in_ch.opcode;
          oid_nxt      = in_ch.target_id;
          cseq_nxt     = in_ch.cmt_seq;
          time_nxt     = in_ch.time_ns;
          sec_nxt      = in_ch.sec;
          nsec_nxt     = in_ch.nsec;
          refr_in_nxt  = in_ch.refresh_in;
          seq_in_nxt   = in_ch.seq_in;
          flags_in_nxt = in_ch.flags_in;
          res_nxt      = '0;
          k_nxt        = '0;
          state_nxt    = ST_EMIT;
          priority if (in_ch.opcode == OP_REQUEST) begin
            if (!bound_r || poid_r == 32'd0 || in_ch.surf_id == 32'd0 ||
                in_ch.target_id == 32'd0) begin
              res_nxt.status = STAT_REJECTED;
            end else begin
              put_idx_nxt = free_idx;
              full_nxt    = &valid_r;
              if ((&valid_r) && (MAX_PENDING > 1)) begin
                state_nxt = ST_SH_RD;
              end else begin
                state_nxt = ST_PUT;
              end
            end
          end else if (in_ch.opcode == OP_PREDICT) begin
            if (!bound_r || last_ref_r == 32'd0 || last_time_r == 64'd0) begin
              res_nxt.status = STAT_NO_PRED;
            end else if (in_ch.time_ns >= last_time_r) begin
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end else begin
              mul_a_nxt = 64'd1;
              state_nxt = ST_MUL_LO;
            end
          end else if (in_ch.opcode == OP_PRESENTED || in_ch.opcode == OP_DISCARDED) begin
            if (in_ch.target_id == poid_r) begin
              res_nxt.status = STAT_IGNORED;
            end else begin
              state_nxt = ST_SC_RD;
            end
          end else begin
            res_nxt.status = STAT_IGNORED;
          end
        end
      end

      // Evict slot 0: move every entry down by one
      ST_SH_RD: begin
        ram_raddr = k_r + 1'b1;
        state_nxt = ST_SH_WR;
      end

      ST_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = ram_rdata;
        if (k_r == SLOT_W'(MAX_PENDING - 2)) begin
          state_nxt = ST_PUT;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_SH_RD;
        end
      end

      // Store the new request
      ST_PUT: begin
        ram_we                 = 1'b1;
        ram_waddr              = put_idx_r;
        ram_wdata.fb_id        = oid_r;
        ram_wdata.cmt_seq      = cseq_r;
        ram_wdata.commit_time  = time_r;
        valid_nxt[put_idx_r]   = 1'b1;
        if (!full_r) begin
          pend_nxt = pend_r + 1'b1;
        end
        res_nxt.status = STAT_STORED;
        res_nxt.fb_id  = oid_r;
        state_nxt      = ST_EMIT;
      end

      // Scan slots for the event's id
      ST_SC_RD: begin
        ram_raddr = k_r;
        state_nxt = ST_SC_CHK;
      end

      ST_SC_CHK: begin
        ent_nxt = ram_rdata;
        if (valid_r[k_r] && ram_rdata.fb_id == oid_r) begin
          valid_nxt[k_r] = 1'b0;
          if (pend_r != '0) begin
            pend_nxt = pend_r - 1'b1;
          end
          res_nxt.done_cmt_seq = ram_rdata.cmt_seq;
          if (op_r == OP_PRESENTED) begin
            mul_a_nxt = sec_r;
            state_nxt = ST_MUL_LO;
          end else begin
            res_nxt.status = STAT_DISCARDED;
            state_nxt      = ST_EMIT;
          end
        end else if (k_r == SLOT_W'(MAX_PENDING - 1)) begin
          res_nxt.status = STAT_NO_MATCH;
          state_nxt      = ST_EMIT;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_SC_RD;
        end
      end

      // Wait for the quotient, then form quotient + 1
      ST_DIV: begin
        if (div_done) begin
          mul_a_nxt = div_quo + 64'd1;
          state_nxt = ST_MUL_LO;
        end
      end

      // Low 64 bits of a 64x32 product in two 32x32 halves
      ST_MUL_LO: begin
        prod_nxt  = 64'(mul_a_r[31:0]) * 64'(mul_b);
        state_nxt = ST_MUL_HI;
      end

      ST_MUL_HI: begin
        lo_nxt    = prod_r;
        prod_nxt  = 64'(mul_a_r[63:32]) * 64'(mul_b);
        state_nxt = ST_SUM;
      end

      ST_SUM: begin
        acc_nxt = sum64;
        if (op_r == OP_PREDICT) begin
          res_nxt.status        = STAT_PREDICTED;
          res_nxt.refresh_per   = last_ref_r;
          res_nxt.next_vsync_ns = sum64;
          state_nxt             = ST_EMIT;
        end else begin
          state_nxt = ST_CALC;
        end
      end

      // Latency, jitter and presentation bookkeeping
      ST_CALC: begin
        res_nxt.status       = STAT_PRESENTED;
        res_nxt.pres_time    = acc_r;
        res_nxt.sequence_res = seq_in_r;
        res_nxt.refresh_per  = refr_in_r;
        res_nxt.flags        = flags_in_r;
        res_nxt.latency      = (acc_r >= ent_r.commit_time) ?
                               (acc_r - ent_r.commit_time) : 64'd0;
        res_nxt.jitter       = (last_time_r != 64'd0 && acc_r > last_time_r) ?
                               (acc_r - last_time_r - 64'(refr_in_r)) : 64'd0;
        last_time_nxt        = acc_r;
        last_ref_nxt         = refr_in_r;
        state_nxt            = ST_EMIT;
      end

      // Hand the result to the output register once it is free
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt          = res_r;
          out_nxt.pend_cnt = PEND_OUT_W'(pend_r);
          out_valid_nxt    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      pend_r      <= '0;
      bound_r     <= 1'b0;
      poid_r      <= '0;
      last_time_r <= '0;
      last_ref_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      pend_r      <= pend_nxt;
      bound_r     <= bound_nxt;
      poid_r      <= poid_nxt;
      last_time_r <= last_time_nxt;
      last_ref_r  <= last_ref_nxt;
    end
  end

  // Advance payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    oid_r      <= oid_nxt;
    cseq_r     <= cseq_nxt;
    time_r     <= time_nxt;
    sec_r      <= sec_nxt;
    nsec_r     <= nsec_nxt;
    refr_in_r  <= refr_in_nxt;
    seq_in_r   <= seq_in_nxt;
    flags_in_r <= flags_in_nxt;
    k_r        <= k_nxt;
    put_idx_r  <= put_idx_nxt;
    full_r     <= full_nxt;
    ent_r      <= ent_nxt;
    mul_a_r    <= mul_a_nxt;
    prod_r     <= prod_nxt;
    lo_r       <= lo_nxt;
    acc_r      <= acc_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  // Drive the channels
  assign cfg_ch.ready         = 1'b1;
  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_r.status;
  assign out_ch.fb_id         = out_r.fb_id;
  assign out_ch.pres_time     = out_r.pres_time;
  assign out_ch.sequence_res  = out_r.sequence_res;
  assign out_ch.refresh_per   = out_r.refresh_per;
  assign out_ch.flags         = out_r.flags;
  assign out_ch.done_cmt_seq  = out_r.done_cmt_seq;
  assign out_ch.latency       = out_r.latency;
  assign out_ch.jitter        = $signed(out_r.jitter);
  assign out_ch.next_vsync_ns = out_r.next_vsync_ns;
  assign out_ch.pend_cnt      = out_r.pend_cnt;

  // Checks
  `FPT_ASSERT_IMP(a_pend_matches_valid, 1'b1, $countones(valid_r) == pend_r,
                  "pending count differs from occupied slots")
  `FPT_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(state_r), "sequencer state not one-hot")
  `FPT_ASSERT_IMP(a_div_done_in_div, div_done, state_r == ST_DIV,
                  "divider finished outside the divide step")
  `FPT_ASSERT_NXT(a_emit_loads_out, state_r == ST_EMIT && (!out_valid_r || out_ch.ready),
                  out_valid_r && state_r == ST_IDLE, "result not loaded on emit")

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the frame presentation tracker: a directed table, then
// random phases under several register settings, each result checked against a predictor or a hand-written status.
// Depends on fpt_pkg, the channel interfaces in fpt_ifs and the tracker RTL.
`timescale 1ns / 1ps

module tb_top;
  import fpt_pkg::*;

  localparam int     CYCLE_LIMIT  = 2000000;
  localparam int     PHASE_ITEMS  = 380;
  localparam longint NS_SEC       = 64'd1000000000;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] oid;
    logic [31:0] surface;
    logic [63:0] cseq;
    logic [63:0] now;
    logic [63:0] sec;
    logic [29:0] nsec;
    logic [31:0] refresh;
    logic [63:0] seq;
    logic [31:0] flags;
  } frame_req_t;

  // Directed row: request plus an optional hand-written status and count
  typedef struct {
    frame_req_t  req;
    bit          typed;
    logic [2:0]  status;
    logic [4:0]  pending;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fpt_cfg_if cfg_ch ();
  fpt_in_if  in_ch ();
  fpt_out_if out_ch ();

  frame_presentation_tracker u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Tracker model state
  bit          mdl_valid [MAX_PENDING];
  logic [31:0] mdl_fid   [MAX_PENDING];
  logic [63:0] mdl_cseq  [MAX_PENDING];
  logic [63:0] mdl_ctime [MAX_PENDING];
  logic [4:0]  mdl_pending;
  logic [63:0] mdl_last_pres;
  logic [31:0] mdl_last_refresh;
  logic [31:0] mdl_presented_cnt;
  logic [31:0] mdl_discarded_cnt;
  bit          mdl_bound;
  logic [31:0] mdl_poid;

  res_t        result_q[$];
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  bit          quiet = 1'b0;
  int          out_stall = 0;
  logic [63:0] now_t = 64'd1000;
  dir_row_t    dir_rows[$];

  // Work out the result of one request and advance the model
  function automatic res_t track_frame(frame_req_t r);
    res_t        o;
    int          s;
    int          idx;
    logic [63:0] pres;
    logic [63:0] last;
    logic [63:0] rr;
    o = '0;
    s = -1;
    idx = -1;
    if (r.op == OP_REQUEST) begin
      if (!mdl_bound || mdl_poid == 0 || r.surface == 0 || r.oid == 0) begin
        o.status = STAT_REJECTED;
      end else begin
        for (int i = 0; i < MAX_PENDING; i++)
          if (!mdl_valid[i] && idx < 0) idx = i;
        if (idx < 0) begin
          // Evict slot 0 and shift the table down
          for (int i = 0; i < MAX_PENDING - 1; i++) begin
            mdl_valid[i] = mdl_valid[i+1];
            mdl_fid[i]   = mdl_fid[i+1];
            mdl_cseq[i]  = mdl_cseq[i+1];
            mdl_ctime[i] = mdl_ctime[i+1];
          end
          idx = MAX_PENDING - 1;
        end else begin
          mdl_pending++;
        end
        mdl_valid[idx] = 1'b1;
        mdl_fid[idx]   = r.oid;
        mdl_cseq[idx]  = r.cseq;
        mdl_ctime[idx] = r.now;
        o.status = STAT_STORED;
        o.fb_id = r.oid;
      end
    end else if (r.op == OP_PREDICT) begin
      rr = {32'd0, mdl_last_refresh};
      last = mdl_last_pres;
      if (!mdl_bound || rr == 0 || last == 0) begin
        o.status = STAT_NO_PRED;
      end else begin
        o.status = STAT_PREDICTED;
        o.refresh_per = mdl_last_refresh;
        if (r.now >= last) o.next_vsync_ns = last + ((r.now - last) / rr + 64'd1) * rr;
        else o.next_vsync_ns = last + rr;
      end
    end else if (r.op == OP_OTHER || r.op > OP_PREDICT || r.oid == mdl_poid) begin
      o.status = STAT_IGNORED;
    end else begin
      for (int i = 0; i < MAX_PENDING; i++)
        if (s < 0 && mdl_valid[i] && mdl_fid[i] == r.oid) s = i;
      if (s < 0) begin
        o.status = STAT_NO_MATCH;
      end else begin
        if (r.op == OP_PRESENTED) begin
          pres = r.sec * NS_SEC + {34'd0, r.nsec};
          o.status = STAT_PRESENTED;
          o.pres_time = pres;
          o.sequence_res = r.seq;
          o.refresh_per = r.refresh;
          o.flags = r.flags;
          o.done_cmt_seq = mdl_cseq[s];
          if (pres >= mdl_ctime[s]) o.latency = pres - mdl_ctime[s];
          if (mdl_last_pres > 0 && pres > mdl_last_pres)
            o.jitter = (pres - mdl_last_pres) - {32'd0, r.refresh};
          mdl_last_pres = pres;
          mdl_last_refresh = r.refresh;
          mdl_presented_cnt++;
        end else begin
          mdl_discarded_cnt++;
          o.status = STAT_DISCARDED;
          o.done_cmt_seq = mdl_cseq[s];
        end
        mdl_valid[s] = 1'b0;
        if (mdl_pending > 0) mdl_pending--;
      end
    end
    o.pend_cnt = mdl_pending;
    return o;
  endfunction

  function automatic frame_req_t mk_req(logic [2:0] op, logic [31:0] oid, logic [31:0] sur,
                                        logic [63:0] cseq, logic [63:0] now,
                                        logic [63:0] sec, logic [29:0] nsec,
                                        logic [31:0] refr, logic [63:0] seq,
                                        logic [31:0] flg);
    frame_req_t r;
    r.op = op; r.oid = oid; r.surface = sur; r.cseq = cseq; r.now = now;
    r.sec = sec; r.nsec = nsec; r.refresh = refr; r.seq = seq; r.flags = flg;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Pick a pending feedback id, or zero when the table is empty
  function automatic logic [31:0] pending_fid();
    int hits[$];
    for (int i = 0; i < MAX_PENDING; i++)
      if (mdl_valid[i]) hits.push_back(i);
    if (hits.size() == 0) return 32'd0;
    return mdl_fid[hits[$urandom_range(0, hits.size() - 1)]];
  endfunction

  // Pick an event target: mostly pending ids, sometimes noise or the bound object
  function automatic logic [31:0] event_target();
    logic [31:0] f;
    int          p;
    p = $urandom_range(0, 99);
    f = pending_fid();
    if (p < 5) return mdl_poid;
    if (p < 15 || f == 0) return (p & 1) ? $urandom : $urandom_range(1, 24);
    return f;
  endfunction

  function automatic frame_req_t random_req();
    frame_req_t r;
    int         p;
    r = mk_req(OP_REQUEST, $urandom, $urandom, rand64(), rand64(), rand64(),
               30'($urandom_range(0, 999999999)), $urandom, rand64(), $urandom);
    now_t = now_t + $urandom_range(1, 20000000);
    if ($urandom_range(0, 19) != 0) r.now = now_t;
    p = $urandom_range(0, 99);
    if (p < 40) begin
      r.op = OP_REQUEST;
      if ($urandom_range(0, 9) < 7) r.oid = $urandom_range(1, 24);
      if ($urandom_range(0, 29) == 0) r.oid = 32'd0;
      if ($urandom_range(0, 19) == 0) r.surface = 32'd0;
    end else if (p < 87) begin
      r.op = (p < 75) ? OP_PRESENTED : OP_DISCARDED;
      r.oid = event_target();
      if ($urandom_range(0, 19) != 0) r.sec = now_t / NS_SEC + $urandom_range(0, 1);
      if ($urandom_range(0, 3) != 0) r.refresh = $urandom_range(1000000, 20000000);
    end else if (p < 90) begin
      r.op = OP_OTHER;
      r.oid = event_target();
    end else if (p < 97) begin
      r.op = OP_PREDICT;
    end else begin
      r.op = 3'($urandom_range(5, 7));
    end
    return r;
  endfunction

  // Drive one request and predict its result on acceptance
  task automatic send_req(frame_req_t r, bit typed, logic [2:0] st, logic [4:0] pend);
    res_t exp_res;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= r.op;
    in_ch.target_id  <= r.oid;
    in_ch.surf_id    <= r.surface;
    in_ch.cmt_seq    <= r.cseq;
    in_ch.time_ns    <= r.now;
    in_ch.sec        <= r.sec;
    in_ch.nsec       <= r.nsec;
    in_ch.refresh_in <= r.refresh;
    in_ch.seq_in     <= r.seq;
    in_ch.flags_in   <= r.flags;
    do @(posedge clk); while (!in_ch.ready);
    exp_res = track_frame(r);
    if (typed) begin
      exp_res = '0;
      exp_res.status = st;
      exp_res.pend_cnt = pend;
    end
    result_q.push_back(exp_res);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_BOUND) mdl_bound = val[0];
    else if (idx == REG_POID) mdl_poid = val;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_row(frame_req_t r, bit typed = 1'b0, logic [2:0] st = STAT_STORED,
                         logic [4:0] pend = 5'd0);
    dir_row_t row;
    row.req = r; row.typed = typed; row.status = st; row.pending = pend;
    dir_rows.push_back(row);
  endtask

  task automatic run_rows();
    foreach (dir_rows[i])
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].status, dir_rows[i].pending);
    dir_rows.delete();
    drain();
  endtask

  // Result ready with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (quiet) begin
      out_ch.ready <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= $urandom_range(0, 5);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result, status %0d", out_ch.status);
        fail_cnt++;
      end else begin
        e = result_q.pop_front();
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_ch.status); fail_cnt++;
        end
        if (out_ch.fb_id !== e.fb_id) begin
          $error("fb_id: expected %h actual %h", e.fb_id, out_ch.fb_id);
          fail_cnt++;
        end
        if (out_ch.pres_time !== e.pres_time) begin
          $error("pres_time: expected %h actual %h", e.pres_time,
                 out_ch.pres_time); fail_cnt++;
        end
        if (out_ch.sequence_res !== e.sequence_res) begin
          $error("sequence_res: expected %h actual %h", e.sequence_res, out_ch.sequence_res);
          fail_cnt++;
        end
        if (out_ch.refresh_per !== e.refresh_per) begin
          $error("refresh_per: expected %h actual %h", e.refresh_per, out_ch.refresh_per);
          fail_cnt++;
        end
        if (out_ch.flags !== e.flags) begin
          $error("flags: expected %h actual %h", e.flags, out_ch.flags); fail_cnt++;
        end
        if (out_ch.done_cmt_seq !== e.done_cmt_seq) begin
          $error("done_cmt_seq: expected %h actual %h", e.done_cmt_seq,
                 out_ch.done_cmt_seq); fail_cnt++;
        end
        if (out_ch.latency !== e.latency) begin
          $error("latency: expected %h actual %h", e.latency, out_ch.latency);
          fail_cnt++;
        end
        if (out_ch.jitter !== e.jitter) begin
          $error("jitter: expected %h actual %h", e.jitter, out_ch.jitter);
          fail_cnt++;
        end
        if (out_ch.next_vsync_ns !== e.next_vsync_ns) begin
          $error("next_vsync_ns: expected %h actual %h", e.next_vsync_ns,
                 out_ch.next_vsync_ns); fail_cnt++;
        end
        if (out_ch.pend_cnt !== e.pend_cnt) begin
          $error("pend_cnt: expected %0d actual %0d", e.pend_cnt,
                 out_ch.pend_cnt); fail_cnt++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [31:0] poid_set [5];
    bit          bound_set [5];
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0; in_ch.target_id = '0; in_ch.surf_id = '0; in_ch.cmt_seq = '0;
    in_ch.time_ns = '0; in_ch.sec = '0; in_ch.nsec = '0; in_ch.refresh_in = '0;
    in_ch.seq_in = '0; in_ch.flags_in = '0;
    for (int i = 0; i < MAX_PENDING; i++) begin
      mdl_valid[i] = 1'b0; mdl_fid[i] = '0; mdl_cseq[i] = '0; mdl_ctime[i] = '0;
    end
    mdl_pending = '0; mdl_last_pres = '0; mdl_last_refresh = '0;
    mdl_presented_cnt = '0; mdl_discarded_cnt = '0; mdl_bound = 1'b0; mdl_poid = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: nothing is bound
    add_row(mk_req(OP_REQUEST, 7, 9, 1, 2, 0, 0, 0, 0, 0), 1'b1, STAT_REJECTED, 5'd0);
    add_row(mk_req(OP_PREDICT, 0, 0, 0, 64'd5000, 0, 0, 0, 0, 0), 1'b1, STAT_NO_PRED, 5'd0);
    add_row(mk_req(3'd7, 7, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, STAT_IGNORED, 5'd0);
    add_row(mk_req(OP_PRESENTED, 5, 0, 0, 0, 1, 1, 1, 1, 1), 1'b1, STAT_NO_MATCH, 5'd0);
    run_rows();

    // Bound but with no object id
    write_reg(REG_BOUND, 32'd1);
    add_row(mk_req(OP_REQUEST, 7, 9, 1, 2, 0, 0, 0, 0, 0), 1'b1, STAT_REJECTED, 5'd0);
    run_rows();

    // Full-range object id: extremes, refusals, eviction, events
    write_reg(REG_POID, 32'hFFFF_FFFF);
    add_row(mk_req(OP_REQUEST, 32'hFFFF_FFFE, 32'hFFFF_FFFF, '1, 64'd0, 0, 0, 0, 0, 0));
    add_row(mk_req(OP_REQUEST, 11, 0, 1, 1000, 0, 0, 0, 0, 0));
    add_row(mk_req(OP_REQUEST, 0, 1, 1, 1000, 0, 0, 0, 0, 0));
    for (int i = 1; i <= 15; i++)
      add_row(mk_req(OP_REQUEST, i, i, 64'(i * 3), 64'd1000, 0, 0, 0, 0, 0));
    add_row(mk_req(OP_REQUEST, 100, 1, 64'd77, 64'd2000, 0, 0, 0, 0, 0));
    add_row(mk_req(OP_PRESENTED, 1, 0, 0, 0, '1, 30'd999999999, '1, '1, '1));
    add_row(mk_req(OP_PRESENTED, 2, 0, 0, 0, 0, 0, 32'd16666666, 64'd5, 32'h1));
    add_row(mk_req(OP_PRESENTED, 32'hFFFF_FFFF, 0, 0, 0, 1, 1, 1, 1, 1));
    add_row(mk_req(OP_OTHER, 3, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(OP_DISCARDED, 3, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(OP_DISCARDED, 3, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(OP_PREDICT, 0, 0, 0, 64'd10, 0, 0, 0, 0, 0));
    add_row(mk_req(OP_PRESENTED, 4, 0, 0, 0, 5, 30'd100, 32'd16666666, 9, 0));
    add_row(mk_req(OP_PREDICT, 0, 0, 0, 64'd10, 0, 0, 0, 0, 0));
    add_row(mk_req(OP_PREDICT, 0, 0, 0, 64'd7000000000, 0, 0, 0, 0, 0));
    add_row(mk_req(OP_PRESENTED, 5, 0, 0, 0, 6, 30'd100, 32'd16666666, 10, 0));
    add_row(mk_req(3'd5, 6, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(3'd6, 6, 0, 0, 0, 0, 0, 0, 0, 0));
    run_rows();

    // Random phases over several register settings; the last runs without idling
    bound_set = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    poid_set  = '{$urandom | 32'd1, $urandom, 32'd1, 32'hFFFF_FFFF, $urandom | 32'h100};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_BOUND, {31'd0, bound_set[ph]});
      write_reg(REG_POID, poid_set[ph]);
      if (ph == 4) quiet = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_req(random_req(), 1'b0, STAT_STORED, 5'd0);
      drain();
    end

    repeat (100) @(posedge clk);
    if (fail_cnt == 0 && result_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
